FILE: hdl/orfd_pkg.sv
// ----------------------------------------------------------------------------
// orfd_pkg
// Shared types and constants for the OOK remote frame decoder.
// ----------------------------------------------------------------------------
package orfd_pkg;

  localparam int unsigned CODE_BITS  = 12;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CNT_W      = 6;

  localparam logic [CNT_W-1:0]     FRAME_LEN   = 6'd50;
  localparam logic [CNT_W-1:0]     DATA_LEN    = 6'd48;
  localparam logic [CNT_W-1:0]     COUNT_MAX   = 6'd63;
  localparam logic [CODE_BITS-1:0] FIXED_MASK  = 12'h600;
  localparam logic [LEN_W-1:0]     THR_RESET   = 16'd28;

  typedef enum logic [1:0] {
    CLS_EQUAL = 2'd0,
    CLS_SHORT = 2'd1,
    CLS_LONG  = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    ST_VALID       = 2'd0,
    ST_BAD_COUNT   = 2'd1,
    ST_BAD_PATTERN = 2'd2,
    ST_NO_FIXED    = 2'd3
  } status_t;

  typedef struct packed {
    logic ok;
    logic bit_val;
    logic short_zero;
  } grp_res_t;

endpackage

FILE: hdl/orfd_group_dec.sv
// ----------------------------------------------------------------------------
// orfd_group_dec
// Matches the four duration classes of one group against the bit patterns.
// ----------------------------------------------------------------------------
module orfd_group_dec
  import orfd_pkg::*;
(
  input  logic [5:0] grp_classes,
  input  cls_t       cls4,
  output grp_res_t   res
);

  logic [1:0] c1;
  logic [1:0] c2;
  logic [1:0] c3;
  logic       head_ok;

  assign c1 = grp_classes[1:0];
  assign c2 = grp_classes[3:2];
  assign c3 = grp_classes[5:4];
  assign head_ok = (c1 == CLS_SHORT) && (c2 == CLS_LONG);

  always_comb begin
    res = '0;
    if (head_ok) begin
      if (c3 == CLS_SHORT && cls4 == CLS_LONG) begin
        res.ok = 1'b1;
      end else if (c3 == CLS_LONG && cls4 == CLS_SHORT) begin
        res.ok      = 1'b1;
        res.bit_val = 1'b1;
      end else if (c3 == CLS_SHORT && cls4 == CLS_SHORT) begin
        res.ok         = 1'b1;
        res.short_zero = 1'b1;
      end
    end
  end

endmodule

FILE: hdl/ook_remote_frame_decoder.sv
// ----------------------------------------------------------------------------
// ook_remote_frame_decoder
// Decodes a 12-bit OOK remote code from a stream of pulse/space durations.
// ----------------------------------------------------------------------------
// A frame's last word is registered in the class stage, then sets out_tvalid.
// Throughput: one word per cycle, but a last word waits while the output
// register holds an unread result; non-final words keep flowing meanwhile.
// Reset: synchronous, active low; clears frame state, threshold back to 28.
// ----------------------------------------------------------------------------
module ook_remote_frame_decoder
  import orfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,     // short_long_threshold
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] pulse_length
  input  logic        in_tlast,     // frame_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata     // [1:0] status, [9:2] unit_code,
                                    // [10] switch_on, [11] group_command
);

  logic [LEN_W-1:0]     thr_r;
  logic                 s1_valid_r;
  cls_t                 s1_cls_r;
  logic                 s1_last_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [5:0]           grp_r, grp_nxt;
  logic [CODE_BITS-1:0] code_r, code_nxt;
  logic                 seen_r, seen_nxt;
  logic                 perr_r, perr_nxt;
  logic                 out_valid_r;
  logic [11:0]          out_data_r, out_data_nxt;

  cls_t                 cls_in;
  logic                 out_free;
  logic                 s1_go;
  logic                 in_acc;
  grp_res_t             grp_res;
  logic [CNT_W-1:0]     cnt_inc;
  logic [CODE_BITS-1:0] code_upd;
  logic                 seen_upd;
  logic                 perr_upd;
  status_t              status;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign s1_go      = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready  = !s1_valid_r || s1_go;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r};

  always_comb begin
    if (in_tdata < thr_r) begin
      cls_in = CLS_SHORT;
    end else if (in_tdata > thr_r) begin
      cls_in = CLS_LONG;
    end else begin
      cls_in = CLS_EQUAL;
    end
  end

  orfd_group_dec u_group_dec (
    .grp_classes (grp_r),
    .cls4        (s1_cls_r),
    .res         (grp_res)
  );

  // frame state update
  always_comb begin
    grp_nxt  = grp_r;
    code_upd = code_r;
    seen_upd = seen_r;
    perr_upd = perr_r;
    cnt_inc  = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 6'd1;
    if (cnt_r < DATA_LEN) begin
      case (cnt_r[1:0])
        2'd0: grp_nxt = {4'b0000, s1_cls_r};
        2'd1: grp_nxt[3:2] = s1_cls_r;
        2'd2: grp_nxt[5:4] = s1_cls_r;
        default: begin
          grp_nxt = '0;
          if (grp_res.ok) begin
            code_upd = {grp_res.bit_val, code_r[CODE_BITS-1:1]};
            seen_upd = seen_r | grp_res.short_zero;
          end else begin
            perr_upd = 1'b1;
          end
        end
      endcase
    end

    if (cnt_inc != FRAME_LEN) begin
      status = ST_BAD_COUNT;
    end else if (perr_upd) begin
      status = ST_BAD_PATTERN;
    end else if ((code_upd & FIXED_MASK) != FIXED_MASK) begin
      status = ST_NO_FIXED;
    end else begin
      status = ST_VALID;
    end

    if (status == ST_VALID) begin
      out_data_nxt = {seen_upd, code_upd[11], code_upd[7:0], status};
    end else begin
      out_data_nxt = {10'b0, status};
    end

    if (s1_last_r) begin
      cnt_nxt  = '0;
      grp_nxt  = '0;
      code_nxt = '0;
      seen_nxt = 1'b0;
      perr_nxt = 1'b0;
    end else begin
      cnt_nxt  = cnt_inc;
      code_nxt = code_upd;
      seen_nxt = seen_upd;
      perr_nxt = perr_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      s1_valid_r  <= 1'b0;
      cnt_r       <= '0;
      grp_r       <= '0;
      code_r      <= '0;
      seen_r      <= 1'b0;
      perr_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_go) begin
        cnt_r  <= cnt_nxt;
        grp_r  <= grp_nxt;
        code_r <= code_nxt;
        seen_r <= seen_nxt;
        perr_r <= perr_nxt;
      end
      if (s1_go && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cls_r  <= cls_in;
      s1_last_r <= in_tlast;
    end
    if (s1_go && s1_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: hdl/orfd_checker.sv
// ----------------------------------------------------------------------------
// orfd_checker
// Port-level checks for the OOK remote frame decoder.
// ----------------------------------------------------------------------------
module orfd_checker
  import orfd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_VALID) |-> out_tdata[15:2] == 14'd0)
    else $error("error result carries non-zero fields");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a frame end two cycles earlier");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind ook_remote_frame_decoder orfd_checker u_orfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ook_remote_frame_decoder. Streams duration words
// (well-formed frames with random codes, broken frames, odd lengths and
// noise) under several thresholds. Random gaps on both sides and one long
// receiver hold-off. Each frame result is checked against an in-bench
// decoder.
// ----------------------------------------------------------------------------
module testbench
  import orfd_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    status_t    status;
    logic [7:0] unit_code;
    logic       switch_on;
    logic       group_command;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  ook_remote_frame_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // {tlast, duration}
  logic [16:0]   duration_queue[$];
  frame_result_t predicted_frames[$];

  bit            in_fire;
  bit            no_gaps;
  bit            hold_req;
  bit            hold_done;
  int            hold_left;
  int            mismatch_count;
  int            cycle_count;
  int            words_added;
  logic [15:0]   gen_thr = THR_RESET;

  // decoder state
  logic [15:0]      thr_now;
  logic [CNT_W-1:0] dur_count;
  cls_t             grp_cls[3];
  logic [11:0]      code_reg;
  logic             short_zero_seen;
  logic             bad_pattern;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic cls_t class_of(logic [15:0] len);
    if (len < thr_now) return CLS_SHORT;
    if (len > thr_now) return CLS_LONG;
    return CLS_EQUAL;
  endfunction

  task automatic clear_frame();
    dur_count       = '0;
    grp_cls         = '{CLS_EQUAL, CLS_EQUAL, CLS_EQUAL};
    code_reg        = '0;
    short_zero_seen = 1'b0;
    bad_pattern     = 1'b0;
  endtask

  task automatic decode_duration(input logic [15:0] len, input logic last);
    cls_t          c;
    frame_result_t res;
    if (dur_count < DATA_LEN) begin
      c = class_of(len);
      if (dur_count[1:0] != 2'd3) begin
        grp_cls[dur_count[1:0]] = c;
      end else if (grp_cls[0] != CLS_SHORT || grp_cls[1] != CLS_LONG) begin
        bad_pattern = 1'b1;
      end else if (grp_cls[2] == CLS_SHORT && c == CLS_LONG) begin
        code_reg = {1'b0, code_reg[11:1]};
      end else if (grp_cls[2] == CLS_LONG && c == CLS_SHORT) begin
        code_reg = {1'b1, code_reg[11:1]};
      end else if (grp_cls[2] == CLS_SHORT && c == CLS_SHORT) begin
        code_reg = {1'b0, code_reg[11:1]};
        short_zero_seen = 1'b1;
      end else begin
        bad_pattern = 1'b1;
      end
    end
    if (dur_count != COUNT_MAX) dur_count = dur_count + 1'b1;
    if (last) begin
      res = '0;
      if (dur_count != FRAME_LEN) res.status = ST_BAD_COUNT;
      else if (bad_pattern) res.status = ST_BAD_PATTERN;
      else if ((code_reg & FIXED_MASK) != FIXED_MASK) res.status = ST_NO_FIXED;
      else res.status = ST_VALID;
      if (res.status == ST_VALID) begin
        res.unit_code     = code_reg[7:0];
        res.switch_on     = code_reg[11];
        res.group_command = short_zero_seen;
      end
      predicted_frames.push_back(res);
      clear_frame();
    end
  endtask

  // monitor and checker
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_n) begin
      in_fire = 1'b0;
      thr_now = THR_RESET;
      clear_frame();
    end else begin
      in_fire = in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) thr_now = cfg_data;
      if (in_fire) decode_duration(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.status        = status_t'(out_tdata[1:0]);
        got.unit_code     = out_tdata[9:2];
        got.switch_on     = out_tdata[10];
        got.group_command = out_tdata[11];
        if (predicted_frames.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word, expected none, got %h", $time, out_tdata);
        end else begin
          want = predicted_frames.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (got.status !== want.status)
              $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            if (got.unit_code !== want.unit_code)
              $display("%0t: unit_code expected %h got %h", $time,
                       want.unit_code, got.unit_code);
            if (got.switch_on !== want.switch_on)
              $display("%0t: switch_on expected %b got %b", $time,
                       want.switch_on, got.switch_on);
            if (got.group_command !== want.group_command)
              $display("%0t: group_command expected %b got %b", $time,
                       want.group_command, got.group_command);
          end
        end
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (duration_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 36)) begin
        {in_tlast, in_tdata} <= duration_queue.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_gaps || ($urandom_range(99) >= 36);
    end
  end

  function automatic logic [15:0] short_len();
    if (gen_thr == 16'd0) return 16'd0;
    if ($urandom_range(3) == 0) return gen_thr - 16'd1;
    return 16'($urandom_range(gen_thr - 1, 0));
  endfunction

  function automatic logic [15:0] long_len();
    if (gen_thr == 16'hFFFF) return 16'hFFFF;
    if ($urandom_range(3) == 0) return gen_thr + 16'd1;
    return 16'($urandom_range(65535, gen_thr + 1));
  endfunction

  // bad_pos >= 0 replaces that duration: by the threshold itself or noise
  task automatic add_frame(input logic [11:0] code, input logic [11:0] sz_mask,
                           input int n_words, input int bad_pos, input bit bad_eq);
    logic [15:0] d;
    logic        b;
    logic        sz;
    int          g;
    for (int i = 0; i < n_words; i++) begin
      if (i < 48) begin
        g  = i / 4;
        b  = code[g];
        sz = sz_mask[g] && !b;
        case (i % 4)
          0:       d = short_len();
          1:       d = long_len();
          2:       d = b ? long_len() : short_len();
          default: d = (b || sz) ? short_len() : long_len();
        endcase
      end else begin
        d = (i % 2 == 0) ? short_len() : long_len();
      end
      if (i == bad_pos) d = bad_eq ? gen_thr : 16'($urandom);
      duration_queue.push_back({i == n_words - 1, d});
    end
    words_added += n_words;
  endtask

  task automatic add_noise(input int n_words);
    logic [15:0] d;
    for (int i = 0; i < n_words; i++) begin
      case ($urandom_range(3))
        0:       d = short_len();
        1:       d = long_len();
        2:       d = gen_thr;
        default: d = 16'($urandom);
      endcase
      duration_queue.push_back({i == n_words - 1, d});
    end
    words_added += n_words;
  endtask

  task automatic set_threshold(input logic [15:0] v);
    while (duration_queue.size() != 0 || in_tvalid || predicted_frames.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_thr = v;
  endtask

  task automatic add_random_frame();
    logic [11:0] code;
    logic [11:0] szm;
    int          k;
    k    = $urandom_range(99);
    code = 12'($urandom);
    if ($urandom_range(99) < 85) code[10:9] = 2'b11;
    szm  = ($urandom_range(2) == 0) ? 12'($urandom) : 12'h000;
    if (k < 55)
      add_frame(code, szm, 50, -1, 1'b0);
    else if (k < 67)
      add_frame(code, szm, 50, $urandom_range(47), $urandom_range(1));
    else if (k < 79)
      add_frame(code, szm, $urandom_range(1) ? $urandom_range(1, 49) : $urandom_range(51, 120),
                -1, 1'b0);
    else
      add_noise(($urandom_range(3) == 0) ? 50 : $urandom_range(1, 12));
  endtask

  initial begin
    int          words_base;
    int          phase;
    logic [15:0] thr_pick;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset threshold
    duration_queue.push_back({1'b1, 16'h0000});
    duration_queue.push_back({1'b1, 16'hFFFF});
    words_added += 2;
    add_frame(12'h600, 12'h000, 50, -1, 1'b0);
    add_frame(12'hFFF, 12'h000, 50, -1, 1'b0);
    add_frame(12'h6A5, 12'h0FF, 50, -1, 1'b0);   // group command
    add_frame(12'hE5A, 12'h000, 50, 13, 1'b1);   // duration equal to threshold
    add_frame(12'h1FF, 12'h000, 50, -1, 1'b0);   // fixed bits missing
    add_frame(12'h600, 12'h000, 49, -1, 1'b0);
    add_frame(12'h600, 12'h000, 51, -1, 1'b0);
    add_frame(12'h7FF, 12'h000, 114, -1, 1'b0);  // count must saturate, not wrap
    add_frame(12'h600, 12'h000, 50, 0, 1'b0);

    // receiver hold-off while short frames keep coming
    set_threshold(16'd28);
    hold_req = 1'b1;
    repeat (6) add_frame(12'($urandom), 12'h000, $urandom_range(1, 4), -1, 1'b0);
    repeat (3) add_frame(12'($urandom) | 12'h600, 12'($urandom), 50, -1, 1'b0);

    // range extremes
    set_threshold(16'd1);
    repeat (3) add_frame(12'($urandom) | 12'h600, 12'($urandom), 50, -1, 1'b0);
    add_noise(20);
    set_threshold(16'hFFFF);
    add_frame(12'hE00, 12'h000, 50, -1, 1'b0);
    add_noise(10);
    set_threshold(16'd0);
    add_frame(12'h600, 12'h000, 50, -1, 1'b0);
    add_noise(5);

    words_base = words_added;
    phase = 0;
    while (words_added < 1300) begin
      case ($urandom_range(9))
        0:       thr_pick = 16'd1;
        1:       thr_pick = 16'hFFFF;
        2:       thr_pick = 16'($urandom_range(3001, 65534));
        default: thr_pick = 16'($urandom_range(2, 3000));
      endcase
      set_threshold(thr_pick);
      no_gaps = (phase == 1);
      while (words_added - words_base < 100 * (phase + 1)) add_random_frame();
      phase++;
    end

    while (duration_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (predicted_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/orfd_pkg.sv
hdl/orfd_group_dec.sv
hdl/ook_remote_frame_decoder.sv
hdl/orfd_checker.sv
test/testbench.sv
